// ===== hw/rtl/gshare_pkg.sv =====
// Shared constants, types and counter arithmetic for the gshare predictor.
package gshare_pkg;

    localparam int TABLE_INDEX_BITS_DEF = 14;
    localparam int HISTORY_BITS_DEF     = 14;
    localparam int PC_WIDTH             = 32;
    localparam int CTR_WIDTH            = 2;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_TRAIN   = 1'b1;

    localparam logic [CTR_WIDTH-1:0] CTR_STRONG_NT = 2'b00;
    localparam logic [CTR_WIDTH-1:0] CTR_STRONG_T  = 2'b11;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } t_state;

    // Move a 2-bit counter one step toward the outcome, saturating at both ends.
    function automatic logic [CTR_WIDTH-1:0] sat_update(input logic [CTR_WIDTH-1:0] ctr,
                                                        input logic taken);
        logic [CTR_WIDTH-1:0] res;
        res = ctr;
        if (taken) begin
            if (ctr != CTR_STRONG_T) begin
                res = ctr + 2'd1;
            end
        end else begin
            if (ctr != CTR_STRONG_NT) begin
                res = ctr - 2'd1;
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/gshare_branch_predictor_unit.sv =====
// Gshare branch predictor: 2-bit counter table indexed by pc XOR global history.
//
// The counter table is a RAM with a registered read, so the cycle after a
// request is accepted holds the read data, the update write and the history
// shift, and busy is high for that cycle. The prediction appears on
// o_predict_taken with o_strobe high for one cycle, the cycle after that, and
// must be captured then. After reset the unit clears all 2**TABLE_INDEX_BITS
// table entries, one entry per cycle, with busy high.
module gshare_branch_predictor_unit #(
    parameter int TABLE_INDEX_BITS = gshare_pkg::TABLE_INDEX_BITS_DEF,
    parameter int HISTORY_BITS     = gshare_pkg::HISTORY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [gshare_pkg::PC_WIDTH-1:0] i_branch_pc,
    input  logic                          i_branch_taken,
    output logic                          o_strobe,
    output logic                          o_predict_taken
);
    import gshare_pkg::*;

    localparam int TableDepth = 1 << TABLE_INDEX_BITS;

    t_state                      r_state, n_state;
    logic [TABLE_INDEX_BITS-1:0] r_clr_addr, n_clr_addr;
    logic [HISTORY_BITS-1:0]     r_hist, n_hist;
    logic                        r_strobe, n_strobe;
    logic [TABLE_INDEX_BITS-1:0] r_idx;
    logic                        r_op;
    logic                        r_taken;
    logic                        r_pred;

    logic                        accept;
    logic [TABLE_INDEX_BITS-1:0] hist_ix;
    logic [TABLE_INDEX_BITS-1:0] rd_addr;
    logic [HISTORY_BITS-1:0]     hist_shift;
    logic                        wr_en;
    logic [TABLE_INDEX_BITS-1:0] wr_addr;
    logic [CTR_WIDTH-1:0]        wr_data;
    logic [CTR_WIDTH-1:0]        rd_data;

    // Fit the history to the index width: high bits drop, short history pads.
    generate
        if (HISTORY_BITS >= TABLE_INDEX_BITS) begin : g_hist_wide
            assign hist_ix = r_hist[TABLE_INDEX_BITS-1:0];
        end else begin : g_hist_narrow
            assign hist_ix = {{(TABLE_INDEX_BITS-HISTORY_BITS){1'b0}}, r_hist};
        end
    endgenerate

    assign busy       = (r_state != ST_IDLE);
    assign accept     = start && !busy;
    assign rd_addr    = i_branch_pc[TABLE_INDEX_BITS-1:0] ^ hist_ix;
    // drop the oldest outcome off the top
    assign hist_shift = HISTORY_BITS'({r_hist, i_branch_taken});

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_hist     = r_hist;
        n_strobe   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_idx;
        wr_data    = sat_update(rd_data, r_taken);
        case (r_state)
            ST_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                wr_data    = CTR_STRONG_NT;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == {TABLE_INDEX_BITS{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_READ;
                    // index already captured, so shift the history now
                    if (i_operation == OP_TRAIN) begin
                        n_hist = hist_shift;
                    end
                end
            end
            ST_READ: begin
                wr_en    = (r_op == OP_TRAIN);
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_hist     <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_hist     <= n_hist;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx   <= rd_addr;
            r_op    <= i_operation;
            r_taken <= i_branch_taken;
        end
        if (r_state == ST_READ) begin
            r_pred <= rd_data[CTR_WIDTH-1];
        end
    end

    gshare_ram #(
        .P_WIDTH (CTR_WIDTH),
        .P_DEPTH (TableDepth)
    ) u_ctr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_strobe        = r_strobe;
    assign o_predict_taken = r_pred;

    a_strobe_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> o_strobe)
        else $error("result strobe missing after table read");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_READ))
        else $error("accepted request did not enter read");

    a_hist_only_on_train: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && (i_operation == OP_TRAIN)) |=> $stable(r_hist))
        else $error("history changed without a train request");

    a_no_strobe_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_strobe)
        else $error("result strobe during table clear");

endmodule

// ===== hw/rtl/gshare_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module gshare_ram #(
    parameter int P_WIDTH = 2,
    parameter int P_DEPTH = 16384
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_wr_addr,
    input  logic [P_WIDTH-1:0]         i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_rd_addr,
    output logic [P_WIDTH-1:0]         o_rd_data
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
